### sv/tts_pkg.sv
// Shared types and constants of the thermistor temperature statistics unit.
// Holds the datapath operation codes, the command/status structs and the
// fixed-point coefficients. No dependencies.
package tts_pkg;

   localparam int SENSOR_W = 16;
   localparam int TEMP_W   = 16;
   localparam int IDX_W    = 4;
   localparam int SUM_W    = 21;
   localparam int VAL_W    = 18;
   localparam int MAG_W    = 32;
   localparam int QUO_W    = 21;
   localparam int PROD_W   = 64;

   // Polynomial coefficients and offsets.
   localparam logic [MAG_W-1:0]        COEF_A = 32'd1092;
   localparam logic [MAG_W-1:0]        DIV_A  = 32'd1000;
   localparam logic [MAG_W-1:0]        DIV_L  = 32'd100000;
   localparam logic signed [VAL_W-1:0] OFS_A  = 18'sd53300;
   localparam logic signed [VAL_W-1:0] OFS_B  = -18'sd12000;
   localparam logic signed [VAL_W-1:0] OFS_T  = 18'sd1219;

   // Reciprocals for the constant divisions: floor(2^SHIFT / divisor).
   localparam int               SHIFT_A   = 40;
   localparam logic [MAG_W-1:0] RECIP_A   = 32'd1099511627;
   localparam int               SHIFT_L   = 47;
   localparam logic [MAG_W-1:0] RECIP_L   = 32'd1407374883;
   localparam int               SHIFT_AVG = 31;

   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sh8000;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_RECIP_A,
      OP_BACK_A,
      OP_FIX_A,
      OP_MUL_V,
      OP_RECIP_L,
      OP_BACK_L,
      OP_FIX_B,
      OP_FIX_T,
      OP_ACCUM,
      OP_AVG_BACK,
      OP_AVG_FIX,
      OP_EMIT
   } tts_op_type;

   typedef struct packed {
      tts_op_type op;
   } tts_cmd_type;

   typedef struct packed {
      logic frame_last;
   } tts_status_type;

endpackage

### sv/thermistor_temperature_statistics_unit.sv
// Thermistor temperature statistics unit: every step of the cubic polynomial,
// its reciprocal divisions and the frame average share one registered
// multiplier, so each transaction is sequenced step by step, with the average
// steps added on the last sample of a frame. A new sample is taken only in the
// cycle after the last result is registered, while that result waits.
// Synchronous active-high reset clears the sequencer and the frame state.
module thermistor_temperature_statistics_unit
   import tts_pkg::*;
#(
   parameter int SENSOR_COUNT = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sensor_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [15:0] temperature, [31:16] frame_min,
                                    // [47:32] frame_max, [63:48] frame_average
   output logic        rsp_tlast    // frame_done
);

   tts_cmd_type              cmd;
   tts_status_type           status;
   logic signed [TEMP_W-1:0] temperature, frame_min, frame_max, frame_average;

   tts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tts_datapath #(
      .SENSOR_COUNT (SENSOR_COUNT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .sensor_code   (req_tdata[SENSOR_W-1:0]),
      .temperature   (temperature),
      .frame_done    (rsp_tlast),
      .frame_min     (frame_min),
      .frame_max     (frame_max),
      .frame_average (frame_average)
   );

   assign rsp_tdata = {frame_average, frame_max, frame_min, temperature};

endmodule

### sv/tts_ctrl.sv
// Sequencer of the thermistor temperature statistics unit.
// Steps the datapath through the conversion and statistics operations and
// owns the handshakes. Depends on tts_pkg.
module tts_ctrl
   import tts_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  tts_status_type status,
   output tts_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_RECIP_A,
      S_BACK_A,
      S_FIX_A,
      S_MUL_B,
      S_RECIP_B,
      S_BACK_B,
      S_FIX_B,
      S_MUL_T,
      S_RECIP_T,
      S_BACK_T,
      S_FIX_T,
      S_ACCUM,
      S_AVG_BACK,
      S_AVG_FIX,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      emit_go;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   // The output register may be reloaded once its transaction completes.
   assign emit_go    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_RECIP_A;
            end
         end
         S_RECIP_A:  begin cmd.op = OP_RECIP_A; state_in = S_BACK_A;  end
         S_BACK_A:   begin cmd.op = OP_BACK_A;  state_in = S_FIX_A;   end
         S_FIX_A:    begin cmd.op = OP_FIX_A;   state_in = S_MUL_B;   end
         S_MUL_B:    begin cmd.op = OP_MUL_V;   state_in = S_RECIP_B; end
         S_RECIP_B:  begin cmd.op = OP_RECIP_L; state_in = S_BACK_B;  end
         S_BACK_B:   begin cmd.op = OP_BACK_L;  state_in = S_FIX_B;   end
         S_FIX_B:    begin cmd.op = OP_FIX_B;   state_in = S_MUL_T;   end
         S_MUL_T:    begin cmd.op = OP_MUL_V;   state_in = S_RECIP_T; end
         S_RECIP_T:  begin cmd.op = OP_RECIP_L; state_in = S_BACK_T;  end
         S_BACK_T:   begin cmd.op = OP_BACK_L;  state_in = S_FIX_T;   end
         S_FIX_T:    begin cmd.op = OP_FIX_T;   state_in = S_ACCUM;   end
         S_ACCUM: begin
            cmd.op   = OP_ACCUM;
            state_in = status.frame_last ? S_AVG_BACK : S_EMIT;
         end
         S_AVG_BACK: begin cmd.op = OP_AVG_BACK; state_in = S_AVG_FIX; end
         S_AVG_FIX:  begin cmd.op = OP_AVG_FIX;  state_in = S_EMIT;    end
         S_EMIT: begin
            if (emit_go) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_EMIT && emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

### sv/tts_datapath.sv
// Datapath of the thermistor temperature statistics unit: one shared
// 32x32 multiplier for the polynomial and the reciprocal divisions, the
// frame accumulators and the result register. Depends on tts_pkg.
module tts_datapath
   import tts_pkg::*;
#(
   parameter int SENSOR_COUNT = 4
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  tts_cmd_type              cmd,
   output tts_status_type           status,
   input  logic [SENSOR_W-1:0]      sensor_code,
   output logic signed [TEMP_W-1:0] temperature,
   output logic                     frame_done,
   output logic signed [TEMP_W-1:0] frame_min,
   output logic signed [TEMP_W-1:0] frame_max,
   output logic signed [TEMP_W-1:0] frame_average
);

   localparam logic [MAG_W-1:0] DIV_AVG   = MAG_W'(SENSOR_COUNT);
   localparam logic [MAG_W-1:0] RECIP_AVG = MAG_W'((64'd1 << SHIFT_AVG) / SENSOR_COUNT);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SENSOR_COUNT - 1);

   // Working registers.
   logic [SENSOR_W-1:0]      x_ff;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic signed [VAL_W-1:0]  value_ff, value_in;
   logic signed [TEMP_W-1:0] temp_ff;

   // Frame state.
   logic [IDX_W-1:0]         index_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [TEMP_W-1:0] min_ff, min_in;
   logic signed [TEMP_W-1:0] max_ff, max_in;

   // Result register.
   logic signed [TEMP_W-1:0] rsp_temp_ff, rsp_min_ff, rsp_max_ff, rsp_avg_ff;
   logic                     rsp_done_ff;

   logic [MAG_W-1:0]         mul_a, mul_b;
   logic [MAG_W-1:0]         value_abs, sum_abs, rem, divisor;
   logic [QUO_W-1:0]         quo_fix;
   logic signed [VAL_W-1:0]  quo_signed, offset;
   logic                     frame_last;

   assign frame_last        = (index_ff >= IDX_LAST);
   assign status.frame_last = frame_last;

   assign value_abs = value_ff[VAL_W-1] ? MAG_W'(-value_ff) : MAG_W'(value_ff);
   assign sum_abs   = sum_in[SUM_W-1] ? MAG_W'(-sum_in) : MAG_W'(sum_in);

   // Frame accumulation of the current temperature.
   always_comb begin
      sum_in = sum_ff + SUM_W'(temp_ff);
      min_in = (temp_ff < min_ff) ? temp_ff : min_ff;
      max_in = (temp_ff > max_ff) ? temp_ff : max_ff;
   end

   // Quotient correction: the reciprocal estimate is either exact or one low.
   always_comb begin
      case (cmd.op)
         OP_FIX_A:   begin divisor = DIV_A;   offset = OFS_A; end
         OP_FIX_B:   begin divisor = DIV_L;   offset = OFS_B; end
         OP_FIX_T:   begin divisor = DIV_L;   offset = OFS_T; end
         OP_AVG_FIX: begin divisor = DIV_AVG; offset = '0;    end
         default:    begin divisor = DIV_L;   offset = '0;    end
      endcase
      rem        = mag_ff - prod_ff[MAG_W-1:0];
      quo_fix    = quo_ff + QUO_W'(rem >= divisor);
      quo_signed = neg_ff ? -$signed({1'b0, quo_fix[VAL_W-2:0]})
                          :  $signed({1'b0, quo_fix[VAL_W-2:0]});
      value_in   = quo_signed + offset;
   end

   // Operand selection of the shared multiplier.
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      quo_in = quo_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      case (cmd.op)
         OP_LOAD: begin
            mul_a  = MAG_W'(sensor_code);
            mul_b  = COEF_A;
            neg_in = 1'b1;
         end
         OP_RECIP_A: begin
            mag_in = prod_ff[MAG_W-1:0];
            mul_a  = prod_ff[MAG_W-1:0];
            mul_b  = RECIP_A;
         end
         OP_BACK_A: begin
            quo_in = QUO_W'(prod_ff[PROD_W-1:SHIFT_A]);
            mul_a  = MAG_W'(quo_in);
            mul_b  = DIV_A;
         end
         OP_MUL_V: begin
            mul_a  = MAG_W'(x_ff);
            mul_b  = value_abs;
            neg_in = value_ff[VAL_W-1];
         end
         OP_RECIP_L: begin
            mag_in = prod_ff[MAG_W-1:0];
            mul_a  = prod_ff[MAG_W-1:0];
            mul_b  = RECIP_L;
         end
         OP_BACK_L: begin
            quo_in = QUO_W'(prod_ff[PROD_W-1:SHIFT_L]);
            mul_a  = MAG_W'(quo_in);
            mul_b  = DIV_L;
         end
         OP_ACCUM: begin
            mag_in = sum_abs;
            neg_in = sum_in[SUM_W-1];
            mul_a  = sum_abs;
            mul_b  = RECIP_AVG;
         end
         OP_AVG_BACK: begin
            quo_in = QUO_W'(prod_ff[PROD_W-1:SHIFT_AVG]);
            mul_a  = MAG_W'(quo_in);
            mul_b  = DIV_AVG;
         end
         default: begin
         end
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // Working and result registers carry no reset.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      case (cmd.op)
         OP_LOAD: begin
            x_ff    <= sensor_code;
            prod_ff <= prod_in;
         end
         OP_RECIP_A, OP_BACK_A, OP_MUL_V, OP_RECIP_L, OP_BACK_L,
         OP_ACCUM, OP_AVG_BACK: begin
            prod_ff <= prod_in;
         end
         OP_FIX_A, OP_FIX_B, OP_AVG_FIX: begin
            value_ff <= value_in;
         end
         OP_FIX_T: begin
            value_ff <= value_in;
            temp_ff  <= value_in[TEMP_W-1:0];
         end
         OP_EMIT: begin
            rsp_temp_ff <= temp_ff;
            rsp_done_ff <= frame_last;
            if (frame_last) begin
               rsp_min_ff <= min_ff;
               rsp_max_ff <= max_ff;
               rsp_avg_ff <= value_ff[TEMP_W-1:0];
            end else begin
               rsp_min_ff <= '0;
               rsp_max_ff <= '0;
               rsp_avg_ff <= '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Frame state.
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         sum_ff   <= '0;
         min_ff   <= TEMP_MAX;
         max_ff   <= TEMP_MIN;
      end else begin
         case (cmd.op)
            OP_ACCUM: begin
               sum_ff <= sum_in;
               min_ff <= min_in;
               max_ff <= max_in;
            end
            OP_EMIT: begin
               if (frame_last) begin
                  index_ff <= '0;
                  sum_ff   <= '0;
                  min_ff   <= TEMP_MAX;
                  max_ff   <= TEMP_MIN;
               end else begin
                  index_ff <= index_ff + IDX_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign temperature   = rsp_temp_ff;
   assign frame_done    = rsp_done_ff;
   assign frame_min     = rsp_min_ff;
   assign frame_max     = rsp_max_ff;
   assign frame_average = rsp_avg_ff;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for thermistor_temperature_statistics_unit.
// Drives raw sensor codes, predicts temperature and frame statistics itself,
// and depends only on tts_pkg and the unit under test.
module testbench
   import tts_pkg::*;
();

   localparam int SENSOR_COUNT  = 4;
   localparam int RANDOM_CODES  = 1200;
   localparam int TABLE_ROWS    = 20;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_AT_ITEM  = 300;
   localparam int HOLD_CYCLES   = 300;
   localparam int STEADY_FIRST  = 600;
   localparam int STEADY_LAST   = 800;
   localparam int IDLE_PERCENT  = 36;
   localparam int PRINT_CAP     = 60;

   typedef struct {
      logic signed [TEMP_W-1:0] temperature;
      logic                     frame_done;
      logic signed [TEMP_W-1:0] frame_min;
      logic signed [TEMP_W-1:0] frame_max;
      logic signed [TEMP_W-1:0] frame_average;
   } reading_type;

   // A row with typed set carries its expected reading; the others use the predictor.
   typedef struct {
      logic [SENSOR_W-1:0]      code;
      bit                       typed;
      logic signed [TEMP_W-1:0] temperature;
      logic                     frame_done;
      logic signed [TEMP_W-1:0] frame_min;
      logic signed [TEMP_W-1:0] frame_max;
      logic signed [TEMP_W-1:0] frame_average;
   } code_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;

   reading_type  expected_readings[$];
   code_row_type code_table[TABLE_ROWS];
   int           accepted_codes;
   int           mismatch_count;
   int           cycle_count;
   bit           steady_stream;

   // Frame state of the predictor.
   int frame_position;
   int frame_sum;
   int frame_lowest;
   int frame_highest;

   thermistor_temperature_statistics_unit #(
      .SENSOR_COUNT(SENSOR_COUNT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void clear_frame_state();
      frame_position = 0;
      frame_sum      = 0;
      frame_lowest   = 32767;
      frame_highest  = -32768;
   endfunction

   // Cubic conversion with truncating divisions, then the frame statistics.
   function automatic reading_type convert_and_accumulate(logic [SENSOR_W-1:0] code);
      reading_type r;
      int x;
      int a;
      int b;
      int t;
      x = int'({16'd0, code});
      a = (x * -1092) / 1000 + 53300;
      b = (x * a) / 100000 - 12000;
      t = (x * b) / 100000 + 1219;
      frame_sum += t;
      if (t < frame_lowest) frame_lowest = t;
      if (t > frame_highest) frame_highest = t;
      r.temperature = t[15:0];
      if (frame_position + 1 >= SENSOR_COUNT) begin
         r.frame_done    = 1'b1;
         r.frame_min     = frame_lowest[15:0];
         r.frame_max     = frame_highest[15:0];
         t               = frame_sum / SENSOR_COUNT;
         r.frame_average = t[15:0];
         clear_frame_state();
      end else begin
         r.frame_done    = 1'b0;
         r.frame_min     = '0;
         r.frame_max     = '0;
         r.frame_average = '0;
         frame_position++;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("MISMATCH at cycle %0d: %s got %0d expected %0d",
                  cycle_count, what, got, want);
   endtask

   // Offers one code, holding it until the unit takes it, then predicts.
   task automatic offer_code(code_row_type row);
      reading_type r;
      while (!steady_stream && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row.code;
      do @(posedge clock); while (!req_tready);
      r = convert_and_accumulate(row.code);
      if (row.typed) begin
         r.temperature   = row.temperature;
         r.frame_done    = row.frame_done;
         r.frame_min     = row.frame_min;
         r.frame_max     = row.frame_max;
         r.frame_average = row.frame_average;
      end
      expected_readings.push_back(r);
      accepted_codes++;
      steady_stream = (accepted_codes >= STEADY_FIRST && accepted_codes < STEADY_LAST);
   endtask

   initial begin : stimulus
      code_row_type row;
      int pick;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      accepted_codes = 0;
      mismatch_count = 0;
      steady_stream  = 1'b0;
      clear_frame_state();

      // Frames of all-zero codes, all-ones codes, alternating extremes, then
      // bit patterns, near-extreme and other codes left to the predictor.
      code_table = '{
         '{16'h0000, 1'b1,   1219, 1'b0,      0,      0,      0},
         '{16'h0000, 1'b1,   1219, 1'b0,      0,      0,      0},
         '{16'h0000, 1'b1,   1219, 1'b0,      0,      0,      0},
         '{16'h0000, 1'b1,   1219, 1'b1,   1219,   1219,   1219},
         '{16'hFFFF, 1'b1, -14489, 1'b0,      0,      0,      0},
         '{16'hFFFF, 1'b1, -14489, 1'b0,      0,      0,      0},
         '{16'hFFFF, 1'b1, -14489, 1'b0,      0,      0,      0},
         '{16'hFFFF, 1'b1, -14489, 1'b1, -14489, -14489, -14489},
         '{16'h0000, 1'b1,   1219, 1'b0,      0,      0,      0},
         '{16'hFFFF, 1'b1, -14489, 1'b0,      0,      0,      0},
         '{16'h0000, 1'b1,   1219, 1'b0,      0,      0,      0},
         '{16'hFFFF, 1'b1, -14489, 1'b1, -14489,   1219,  -6635},
         '{16'h5555, 1'b0,      0, 1'b0,      0,      0,      0},
         '{16'hAAAA, 1'b0,      0, 1'b0,      0,      0,      0},
         '{16'h8000, 1'b0,      0, 1'b0,      0,      0,      0},
         '{16'h7FFF, 1'b0,      0, 1'b0,      0,      0,      0},
         '{16'h0001, 1'b0,      0, 1'b0,      0,      0,      0},
         '{16'hFFFE, 1'b0,      0, 1'b0,      0,      0,      0},
         '{16'h0100, 1'b0,      0, 1'b0,      0,      0,      0},
         '{16'h1234, 1'b0,      0, 1'b0,      0,      0,      0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < TABLE_ROWS; i++)
         offer_code(code_table[i]);

      row = code_table[TABLE_ROWS-1];
      row.typed = 1'b0;
      for (int i = 0; i < RANDOM_CODES; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5)
            row.code = 16'h0000;
         else if (pick < 10)
            row.code = 16'hFFFF;
         else if (pick < 20)
            row.code = 16'($urandom_range(0, 255));
         else
            row.code = 16'($urandom_range(0, 65535));
         offer_code(row);
      end
      req_tvalid <= 1'b0;

      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Result side pacing, with one long hold-off that backs the unit up.
   initial begin : sink_pacing
      int hold_left;
      bit hold_done;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && accepted_codes >= HOLD_AT_ITEM) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (steady_stream) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            report_mismatch("unexpected transaction, temperature",
                            int'($signed(rsp_tdata[15:0])), 0);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_tdata[15:0] !== want.temperature)
               report_mismatch("temperature", int'($signed(rsp_tdata[15:0])),
                               int'(want.temperature));
            if (rsp_tlast !== want.frame_done)
               report_mismatch("frame_done", int'(rsp_tlast), int'(want.frame_done));
            if (rsp_tdata[31:16] !== want.frame_min)
               report_mismatch("frame_min", int'($signed(rsp_tdata[31:16])),
                               int'(want.frame_min));
            if (rsp_tdata[47:32] !== want.frame_max)
               report_mismatch("frame_max", int'($signed(rsp_tdata[47:32])),
                               int'(want.frame_max));
            if (rsp_tdata[63:48] !== want.frame_average)
               report_mismatch("frame_average", int'($signed(rsp_tdata[63:48])),
                               int'(want.frame_average));
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

endmodule
